### rtl/hslr_pkg.sv
package hslr_pkg;

  localparam int CH_W       = 8;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int HUE_W      = 11;
  localparam int DIV_NUM_W  = 17;
  localparam int DIV_DEN_W  = 9;
  localparam int DIV_Q_W    = 9;
  localparam int DIV_STAGES = 3;
  localparam int DIV_STEPS  = DIV_Q_W / DIV_STAGES;
  localparam int PIPE_LAT   = 9;

  localparam logic [HUE_W-1:0] HUE_RED   = 11'd0;
  localparam logic [HUE_W-1:0] HUE_GREEN = 11'd512;
  localparam logic [HUE_W-1:0] HUE_BLUE  = 11'd1024;
  localparam logic [HUE_W-1:0] HUE_FULL  = 11'd1536;

  localparam logic [ADDR_W-1:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [CH_W-1:0]   BRIGHTNESS_RST = 8'd255;

  // sextant codes of the hue
  localparam logic [2:0] SEXT_RY = 3'd0;
  localparam logic [2:0] SEXT_YG = 3'd1;
  localparam logic [2:0] SEXT_GC = 3'd2;
  localparam logic [2:0] SEXT_CB = 3'd3;
  localparam logic [2:0] SEXT_BM = 3'd4;

  // sideband that rides alongside the two dividers
  typedef struct packed {
    logic             vld;
    logic [CH_W-1:0]  ln;
    logic [HUE_W-1:0] hoff;
    logic             neg;
  } side_t;

  // floor(x / 255) for x below 65280
  function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // (v + 32640) / 65280, clamped to 255
  function automatic logic [CH_W-1:0] to_channel(input logic [24:0] v);
    logic [25:0] s;
    logic [17:0] w;
    s = {1'b0, v} + 26'd32640;
    w = s[25:8];
    if (w >= 18'd65280) return 8'd255;
    return div255(w[15:0]);
  endfunction

endpackage

### rtl/hslr_div.sv
module hslr_div (
  input  logic                          clk,
  input  logic [hslr_pkg::DIV_NUM_W-1:0] num,
  input  logic [hslr_pkg::DIV_DEN_W-1:0] den,
  output logic [hslr_pkg::DIV_Q_W-1:0]   quo
);
  import hslr_pkg::*;

  logic [DIV_NUM_W-1:0] rem_r [0:DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_r [0:DIV_STAGES];
  logic [DIV_Q_W-1:0]   quo_r [0:DIV_STAGES];

  assign rem_r[0] = num;
  assign den_r[0] = den;
  assign quo_r[0] = '0;

  // restoring division, three quotient bits per stage, msb first
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_NUM_W-1:0] rem_next;
    logic [DIV_Q_W-1:0]   quo_next;

    always_comb begin
      logic [DIV_NUM_W-1:0] sh;
      rem_next = rem_r[s];
      quo_next = quo_r[s];
      for (int j = 0; j < DIV_STEPS; j++) begin
        sh = {{(DIV_NUM_W-DIV_DEN_W){1'b0}}, den_r[s]} << (DIV_Q_W - 1 - s*DIV_STEPS - j);
        if (rem_next >= sh) begin
          rem_next = rem_next - sh;
          quo_next[DIV_Q_W - 1 - s*DIV_STEPS - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s+1] <= rem_next;
      den_r[s+1] <= den_r[s];
      quo_r[s+1] <= quo_next;
    end
  end

  assign quo = quo_r[DIV_STAGES];

endmodule

### rtl/hsl_lightness_rescale_core.sv
// hsl lightness rescale core
// takes one rgb pixel per start pulse, keeps hue and saturation and scales
// hsl lightness by brightness_scale / 255, then converts back to rgb.
// input channel: red_in, green_in, blue_in sampled when start is high and
// busy is low. busy is tied low, so a pixel can enter on every cycle.
// output channel: red_out, green_out, blue_out are valid for one cycle while
// done is high; the receiver cannot hold them off.
// throughput is one pixel per cycle. the depth is the input register, the operand
// stage, the two 9-bit quotient dividers (saturation and hue, three bits per
// stage), three back-conversion stages and the output register.
// config: brightness_scale at byte address 0 over the apb port, reset 255.
// the user must write it only while no pixel is in flight; the block does not enforce it.
// reset clears the valid pipeline and restores brightness_scale.
module hsl_lightness_rescale_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [hslr_pkg::CH_W-1:0]   red_in,
  input  logic [hslr_pkg::CH_W-1:0]   green_in,
  input  logic [hslr_pkg::CH_W-1:0]   blue_in,
  output logic                        done,
  output logic [hslr_pkg::CH_W-1:0]   red_out,
  output logic [hslr_pkg::CH_W-1:0]   green_out,
  output logic [hslr_pkg::CH_W-1:0]   blue_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hslr_pkg::ADDR_W-1:0] paddr,
  input  logic [hslr_pkg::DATA_W-1:0] pwdata,
  output logic [hslr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import hslr_pkg::*;

  logic [CH_W-1:0] brightness;
  logic            cfg_wr;

  // config register
  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[ADDR_W-1:2] == REG_BRIGHTNESS[ADDR_W-1:2]);
  assign prdata = (paddr[ADDR_W-1:2] == REG_BRIGHTNESS[ADDR_W-1:2]) ?
                  {{(DATA_W-CH_W){1'b0}}, brightness} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHTNESS_RST;
    end else if (cfg_wr) begin
      brightness <= pwdata[CH_W-1:0];
    end
  end

  // stage 0: input registers
  logic            v0;
  logic [CH_W-1:0] r0, g0, b0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= start && !busy;
    r0 <= red_in;
    g0 <= green_in;
    b0 <= blue_in;
  end

  // stage 1: max, min, divider operands, lightness product
  logic [CH_W-1:0]      mx, mn, dd, ha, hb;
  logic [CH_W:0]        sm;
  logic [CH_W-1:0]      lt, den;
  logic [CH_W-1:0]      mag;
  logic [HUE_W-1:0]     hoff;
  logic [DIV_NUM_W-1:0] sat_num_next, hue_num_next, sat_num, hue_num;
  logic [DIV_DEN_W-1:0] sat_den_next, hue_den_next, sat_den, hue_den;
  logic                 gray;
  logic [15:0]          prod_next, prod;
  side_t                side1_next;
  logic                 v1;
  logic                 neg1;
  logic [HUE_W-1:0]     hoff1;

  always_comb begin
    mx = r0;
    if (g0 > mx) mx = g0;
    if (b0 > mx) mx = b0;
    mn = r0;
    if (g0 < mn) mn = g0;
    if (b0 < mn) mn = b0;
    dd   = mx - mn;
    sm   = {1'b0, mx} + {1'b0, mn};
    lt   = 8'((sm + 9'd1) >> 1);
    den  = (sm <= 9'd255) ? sm[CH_W-1:0] : 8'(9'd510 - sm);
    gray = (dd == '0);
    if (mx == r0) begin
      ha = g0; hb = b0; hoff = HUE_RED;
    end else if (mx == g0) begin
      ha = b0; hb = r0; hoff = HUE_GREEN;
    end else begin
      ha = r0; hb = g0; hoff = HUE_BLUE;
    end
    mag = (ha >= hb) ? ha - hb : hb - ha;
    // gray pixels divide 0 by 1 so both quotients come out zero
    sat_num_next = gray ? '0 : 17'({dd, 9'd0} - {8'd0, dd, 1'b0} + {9'd0, den});
    sat_den_next = gray ? 9'd1 : {den, 1'b0};
    hue_num_next = gray ? '0 : 17'({mag, 9'd0} + {9'd0, dd});
    hue_den_next = gray ? 9'd1 : {dd, 1'b0};
    prod_next    = lt * brightness;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
    sat_num <= sat_num_next;
    sat_den <= sat_den_next;
    hue_num <= hue_num_next;
    hue_den <= hue_den_next;
    prod    <= prod_next;
    neg1    <= !gray && (ha < hb);
    hoff1   <= gray ? HUE_RED : hoff;
  end

  // ln = round(lt * brightness / 255)
  assign side1_next = '{vld: v1, ln: div255(16'(prod + 16'd127)), hoff: hoff1, neg: neg1};

  // stages 2 to 4: dividers with sideband delay line
  logic [DIV_Q_W-1:0] sat_q, hue_q;
  side_t              side_r [1:DIV_STAGES];

  hslr_div u_sat_div (.clk(clk), .num(sat_num), .den(sat_den), .quo(sat_q));
  hslr_div u_hue_div (.clk(clk), .num(hue_num), .den(hue_den), .quo(hue_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= DIV_STAGES; i++) side_r[i].vld <= 1'b0;
    end else begin
      side_r[1].vld <= side1_next.vld;
      for (int i = 2; i <= DIV_STAGES; i++) side_r[i].vld <= side_r[i-1].vld;
    end
    side_r[1].ln   <= side1_next.ln;
    side_r[1].hoff <= side1_next.hoff;
    side_r[1].neg  <= side1_next.neg;
    for (int i = 2; i <= DIV_STAGES; i++) begin
      side_r[i].ln   <= side_r[i-1].ln;
      side_r[i].hoff <= side_r[i-1].hoff;
      side_r[i].neg  <= side_r[i-1].neg;
    end
  end

  // stage 5: hue wrap, saturation clamp, chroma span
  side_t              s4;
  logic signed [12:0] hs;
  logic [HUE_W-1:0]   hue_next, hue5;
  logic [CH_W-1:0]    sat_next, span_next, sat5, span5, ln5;
  logic               v5;

  assign s4 = side_r[DIV_STAGES];

  always_comb begin
    hs = s4.neg ? $signed({2'b0, s4.hoff}) - $signed({4'b0, hue_q})
                : $signed({2'b0, s4.hoff}) + $signed({4'b0, hue_q});
    if (hs < 0) hs = hs + $signed({2'b0, HUE_FULL});
    hue_next  = hs[HUE_W-1:0];
    sat_next  = (sat_q > 9'd255) ? 8'd255 : sat_q[CH_W-1:0];
    span_next = s4.ln[CH_W-1] ? 8'(9'd510 - {s4.ln, 1'b0}) : {s4.ln[CH_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= s4.vld;
    hue5  <= hue_next;
    sat5  <= sat_next;
    span5 <= span_next;
    ln5   <= s4.ln;
  end

  // stage 6: span times saturation
  logic [15:0]      ss6;
  logic [HUE_W-1:0] hue6;
  logic [CH_W-1:0]  ln6;
  logic             v6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    ss6  <= span5 * sat5;
    hue6 <= hue5;
    ln6  <= ln5;
  end

  // stage 7: secondary component and channel sums per sextant
  logic [8:0]  t6, fx;
  logic [23:0] xu, cu, mu;
  logic [24:0] rv_next, gv_next, bv_next, rv7, gv7, bv7;
  logic        v7;

  always_comb begin
    t6 = hue6[8:0];
    fx = (t6 >= 9'd256) ? 9'(10'd512 - {1'b0, t6}) : t6;
    xu = {8'd0, ss6} * {15'd0, fx};
    cu = {ss6, 8'd0};
    mu = {ln6, 16'd0} - {8'd0, ln6, 8'd0} - {1'b0, ss6, 7'd0};
    unique case (hue6[HUE_W-1:8])
      SEXT_RY: begin rv_next = {1'b0, cu}; gv_next = {1'b0, xu}; bv_next = '0; end
      SEXT_YG: begin rv_next = {1'b0, xu}; gv_next = {1'b0, cu}; bv_next = '0; end
      SEXT_GC: begin rv_next = '0; gv_next = {1'b0, cu}; bv_next = {1'b0, xu}; end
      SEXT_CB: begin rv_next = '0; gv_next = {1'b0, xu}; bv_next = {1'b0, cu}; end
      SEXT_BM: begin rv_next = {1'b0, xu}; gv_next = '0; bv_next = {1'b0, cu}; end
      default: begin rv_next = {1'b0, cu}; gv_next = '0; bv_next = {1'b0, xu}; end
    endcase
    rv_next = rv_next + {1'b0, mu};
    gv_next = gv_next + {1'b0, mu};
    bv_next = bv_next + {1'b0, mu};
  end

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    rv7 <= rv_next;
    gv7 <= gv_next;
    bv7 <= bv_next;
  end

  // stage 8: scale back to 8-bit channels
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v7;
    red_out   <= to_channel(rv7);
    green_out <= to_channel(gv7);
    blue_out  <= to_channel(bv7);
  end

  // every accepted pixel comes out exactly the pipeline depth later
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##PIPE_LAT done)
    else $error("pixel lost in pipeline");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a pixel");

  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> brightness == $past(pwdata[CH_W-1:0]))
    else $error("brightness write lost");

  a_quot: assert property (@(posedge clk) disable iff (rst)
    s4.vld |-> (sat_q <= 9'd256) && (hue_q <= 9'd256))
    else $error("divider quotient out of range");

endmodule
